/* hdl/pbc_pkg.sv */
// ----------------------------------------------------------------------------
// pbc_pkg
// Types, constants and mode codes shared by the pixel blend compositor.
// ----------------------------------------------------------------------------
package pbc_pkg;

  localparam logic [2:0] ModeNormal   = 3'd0;
  localparam logic [2:0] ModeMultiply = 3'd1;
  localparam logic [2:0] ModeScreen   = 3'd2;
  localparam logic [2:0] ModeOverlay  = 3'd3;
  localparam logic [2:0] ModeDarken   = 3'd4;
  localparam logic [2:0] ModeLighten  = 3'd5;

  localparam int unsigned MidDepth  = 4;
  localparam int unsigned MidAw     = 2;
  localparam int unsigned OutDepth  = 16;
  localparam int unsigned OutAw     = 4;
  localparam int unsigned DivStages = 9;
  localparam int unsigned XW        = 34;
  localparam int unsigned DW        = 25;
  localparam int unsigned Lanes     = 3;

  typedef struct packed {
    logic [7:0] dst_red;
    logic [7:0] dst_green;
    logic [7:0] dst_blue;
    logic [7:0] dst_alpha;
    logic [7:0] src_red;
    logic [7:0] src_green;
    logic [7:0] src_blue;
    logic [7:0] src_alpha;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
  } pix_out_t;

  typedef struct packed {
    logic [7:0]  d;
    logic [7:0]  s;
    logic [15:0] b;
  } chan_t;

  // item handed from front to back
  typedef struct packed {
    chan_t [2:0] ch;
    logic [15:0] p1;
    logic [15:0] p2;
    logic [15:0] p3;
    logic [15:0] oa;
    logic        zero;
  } frt_t;

endpackage

/* hdl/pixel_blend_composite.sv */
// ----------------------------------------------------------------------------
// pixel_blend_composite
// Separable blend mode followed by source-over compositing of RGBA8 pixels.
// ----------------------------------------------------------------------------
// One pixel pair is accepted per clock and one composited pixel leaves per
// clock when the result side pops steadily. A result reaches the output
// queue through one input stage, the hand-off queue, a multiply stage, a
// sum stage and a nine-stage restoring divider that forms one quotient bit
// per stage. The 16-entry result queue bounds how many items may be in
// flight; the input side reports full only once it is filled back to the
// input stage. Write the blend mode only while idle.
module pixel_blend_composite import pbc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  pix_in_t    in_data,
  output logic       out_empty,
  input  logic       out_pop,
  output pix_out_t   out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_data
);

  logic [2:0] mode_r;
  logic       q_push;
  logic       q_full;
  logic       q_pop;
  logic       q_empty;
  frt_t       q_wdata;
  frt_t       q_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= ModeNormal;
    end else if (cfg_valid) begin
      mode_r <= cfg_data;
    end
  end

  pbc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_data (in_data),
    .in_full (in_full),
    .mode    (mode_r),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_data  (q_wdata)
  );

  pbc_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_wdata),
    .full    (q_full),
    .pop     (q_pop),
    .rd_data (q_rdata),
    .empty   (q_empty)
  );

  pbc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (q_rdata),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule

/* hdl/pbc_front.sv */
// ----------------------------------------------------------------------------
// pbc_front
// Input register stage: forms blend terms and alpha weight products.
// ----------------------------------------------------------------------------
module pbc_front import pbc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_push,
  input  pix_in_t in_data,
  output logic    in_full,
  input  logic [2:0] mode,
  input  logic    q_full,
  output logic    q_push,
  output frt_t    q_data
);

  logic    front_v_r;
  logic    front_v_nxt;
  frt_t    item_r;
  frt_t    item_nxt;
  logic    accept;
  logic [7:0] dv [3];
  logic [7:0] sv [3];

  assign in_full = front_v_r & q_full;
  assign accept  = in_push & ~in_full;
  assign q_push  = front_v_r & ~q_full;
  assign q_data  = item_r;
  assign front_v_nxt = accept | (front_v_r & q_full);

  assign dv[0] = in_data.dst_red;
  assign dv[1] = in_data.dst_green;
  assign dv[2] = in_data.dst_blue;
  assign sv[0] = in_data.src_red;
  assign sv[1] = in_data.src_green;
  assign sv[2] = in_data.src_blue;

  always_comb begin
    logic [7:0]  da;
    logic [7:0]  sa;
    logic [7:0]  ma;
    logic [7:0]  mb;
    logic [15:0] prod;
    logic        inv;
    logic [7:0]  mn;
    logic [7:0]  mx;
    da = in_data.dst_alpha;
    sa = in_data.src_alpha;
    item_nxt.p1 = {8'd0, sa} * {8'd0, 8'd255 - da};
    item_nxt.p2 = {8'd0, sa} * {8'd0, da};
    item_nxt.p3 = {8'd0, 8'd255 - sa} * {8'd0, da};
    item_nxt.oa = 16'(({8'd0, sa} << 8) - {8'd0, sa}) + item_nxt.p3;
    item_nxt.zero = (sa == 8'd0) && (da == 8'd0);
    for (int c = 0; c < 3; c++) begin
      // screen and the upper half of overlay work on complements
      inv  = (mode == ModeScreen) || ((mode == ModeOverlay) && dv[c][7]);
      ma   = inv ? 8'd255 - dv[c] : dv[c];
      mb   = inv ? 8'd255 - sv[c] : sv[c];
      prod = {8'd0, ma} * {8'd0, mb};
      mn   = (dv[c] < sv[c]) ? dv[c] : sv[c];
      mx   = (dv[c] > sv[c]) ? dv[c] : sv[c];
      item_nxt.ch[c].d = dv[c];
      item_nxt.ch[c].s = sv[c];
      unique case (mode)
        ModeMultiply: item_nxt.ch[c].b = prod;
        ModeScreen:   item_nxt.ch[c].b = 16'd65025 - prod;
        ModeOverlay:  item_nxt.ch[c].b = inv ? 16'd65025 - {prod[14:0], 1'b0}
                                             : {prod[14:0], 1'b0};
        ModeDarken:   item_nxt.ch[c].b = ({8'd0, mn} << 8) - {8'd0, mn};
        ModeLighten:  item_nxt.ch[c].b = ({8'd0, mx} << 8) - {8'd0, mx};
        default:      item_nxt.ch[c].b = ({8'd0, sv[c]} << 8) - {8'd0, sv[c]};
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_v_r <= 1'b0;
    end else begin
      front_v_r <= front_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= item_nxt;
    end
  end

endmodule

/* hdl/pbc_queue.sv */
// ----------------------------------------------------------------------------
// pbc_queue
// Small register queue between the front and back parts.
// ----------------------------------------------------------------------------
module pbc_queue import pbc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  frt_t wr_data,
  output logic full,
  input  logic pop,
  output frt_t rd_data,
  output logic empty
);

  frt_t             mem_r [MidDepth];
  logic [MidAw-1:0] wr_ptr_r;
  logic [MidAw-1:0] rd_ptr_r;
  logic [MidAw:0]   cnt_r;
  logic             do_push;
  logic             do_pop;

  assign full    = (cnt_r == (MidAw+1)'(MidDepth));
  assign empty   = (cnt_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + (MidAw+1)'(do_push) - (MidAw+1)'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

/* hdl/pbc_back.sv */
// ----------------------------------------------------------------------------
// pbc_back
// Weighted mix, pipelined restoring divide by output alpha, result queue.
// ----------------------------------------------------------------------------
module pbc_back import pbc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     q_empty,
  input  frt_t     q_data,
  output logic     q_pop,
  output logic     out_empty,
  input  logic     out_pop,
  output pix_out_t out_data
);

  logic           issue;
  logic [OutAw:0] credit_r;
  logic           do_pop;

  // mix stage registers
  logic           bv_r;
  logic [23:0]    t1_r [3];
  logic [31:0]    t2_r [3];
  logic [23:0]    t3_r [3];
  logic [15:0]    boa_r;
  logic           bz_r;

  // divider pipeline, stage 0 is the loaded dividend
  logic [XW-1:0]  rem_r [DivStages+1][Lanes];
  logic [DW-1:0]  den_r [DivStages+1][Lanes];
  logic [8:0]     quo_r [DivStages+1][Lanes];
  logic           dz_r  [DivStages+1];
  logic           dv_r  [DivStages+1];
  logic [7:0]     alpha_r [DivStages+1];

  pix_out_t         ofifo_r [OutDepth];
  logic [OutAw-1:0] owr_r;
  logic [OutAw-1:0] ord_r;
  logic [OutAw:0]   ocnt_r;
  pix_out_t         res;
  logic [7:0]       lane_res [Lanes];

  // credits cover everything in flight plus what waits in the result queue
  assign issue     = ~q_empty && (credit_r < (OutAw+1)'(OutDepth));
  assign q_pop     = issue;
  assign do_pop    = out_pop & ~out_empty;
  assign out_empty = (ocnt_r == '0);
  assign out_data  = ofifo_r[ord_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      credit_r <= '0;
    end else begin
      credit_r <= credit_r + (OutAw+1)'(issue) - (OutAw+1)'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bv_r <= 1'b0;
    end else begin
      bv_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      t1_r[c] <= {8'd0, q_data.p1} * {16'd0, q_data.ch[c].s};
      t2_r[c] <= {16'd0, q_data.p2} * {16'd0, q_data.ch[c].b};
      t3_r[c] <= {8'd0, q_data.p3} * {16'd0, q_data.ch[c].d};
    end
    boa_r <= q_data.oa;
    bz_r  <= q_data.zero;
  end

  // sum stage: dividend 2*N + 255*OA over divisor 510*OA
  always_ff @(posedge clk) begin
    logic [24:0] sum;
    logic [32:0] n;
    logic [23:0] oa255;
    logic [16:0] ax;
    logic [32:0] aq;
    for (int c = 0; c < 3; c++) begin
      sum   = {1'b0, t1_r[c]} + {1'b0, t3_r[c]};
      n     = (({8'd0, sum} << 8) - {8'd0, sum}) + {1'b0, t2_r[c]};
      oa255 = ({8'd0, boa_r} << 8) - {8'd0, boa_r};
      rem_r[0][c] <= {n, 1'b0} + {10'd0, oa255};
      den_r[0][c] <= ({9'd0, boa_r} << 9) - ({9'd0, boa_r} << 1);
      quo_r[0][c] <= '0;
    end
    // out alpha is (oa + 127) / 255, by reciprocal multiply
    ax = {1'b0, boa_r} + 17'd127;
    aq = {16'd0, ax} * 33'd32897;
    alpha_r[0] <= aq[30:23];
    dz_r[0]    <= bz_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r[0] <= 1'b0;
    end else begin
      dv_r[0] <= bv_r;
    end
  end

  for (genvar k = 1; k <= DivStages; k++) begin : g_div
    always_ff @(posedge clk) begin
      logic [XW-1:0] sub;
      logic          ge;
      for (int l = 0; l < Lanes; l++) begin
        sub = {{(XW-DW){1'b0}}, den_r[k-1][l]} << (DivStages - k);
        ge  = rem_r[k-1][l] >= sub;
        rem_r[k][l] <= ge ? rem_r[k-1][l] - sub : rem_r[k-1][l];
        den_r[k][l] <= den_r[k-1][l];
        quo_r[k][l] <= {quo_r[k-1][l][7:0], ge};
      end
      dz_r[k]    <= dz_r[k-1];
      alpha_r[k] <= alpha_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[k] <= 1'b0;
      end else begin
        dv_r[k] <= dv_r[k-1];
      end
    end
  end

  always_comb begin
    for (int l = 0; l < Lanes; l++) begin
      if (dz_r[DivStages]) begin
        lane_res[l] = 8'd0;
      end else if (quo_r[DivStages][l][8]) begin
        lane_res[l] = 8'd255;
      end else begin
        lane_res[l] = quo_r[DivStages][l][7:0];
      end
    end
    res.out_red   = lane_res[0];
    res.out_green = lane_res[1];
    res.out_blue  = lane_res[2];
    res.out_alpha = alpha_r[DivStages];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owr_r  <= '0;
      ord_r  <= '0;
      ocnt_r <= '0;
    end else begin
      if (dv_r[DivStages]) begin
        owr_r <= owr_r + 1'b1;
      end
      if (do_pop) begin
        ord_r <= ord_r + 1'b1;
      end
      ocnt_r <= ocnt_r + (OutAw+1)'(dv_r[DivStages]) - (OutAw+1)'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (dv_r[DivStages]) begin
      ofifo_r[owr_r] <= res;
    end
  end

endmodule

/* hdl/pbc_checker.sv */
// ----------------------------------------------------------------------------
// pbc_checker
// Port-level checks for the pixel blend compositor.
// ----------------------------------------------------------------------------
module pbc_checker import pbc_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       out_empty,
  input logic       out_pop,
  input pix_out_t   out_data
);

  // nothing is left in the result queue after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

  // zero alpha only comes from two clear pixels, so color is zero too
  a_clear_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_data.out_alpha == 8'd0) |->
    (out_data.out_red == 8'd0 && out_data.out_green == 8'd0 &&
     out_data.out_blue == 8'd0))
    else $error("clear pixel with nonzero color");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> !out_empty)
    else $error("waiting result withdrawn");

  a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> $stable(out_data))
    else $error("waiting result changed");

endmodule

bind pixel_blend_composite pbc_checker u_pbc_checker (.*);
